/* rtl/plm_pkg.sv */
// shared types, constants and command/status structs for the lens ray shooter
`default_nettype none
package plm_pkg;
    localparam int MAX_LENSES = 16;
    localparam int IDX_W      = $clog2(MAX_LENSES);
    localparam int CNT_W      = 5;
    localparam int COORD_W    = 32;
    localparam int MASS_W     = 32;
    localparam int SCALE_W    = 32;
    localparam int MAG_W      = 32;
    localparam int SIZE_W     = 13;
    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAX_SIZE   = 4096;
    localparam int DIV_W      = 96;
    localparam int QUO_W      = 53;
    localparam int DSTEP_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENS_COUNT,
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_SCALE_X,
        CFG_SCALE_Y,
        CFG_IMAGE_SIZE
    } cfg_reg_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RAY  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_FETCH,
        OP_DIFF,
        OP_SQUARE,
        OP_R2,
        OP_SKIP,
        OP_DIV_START,
        OP_APPLY,
        OP_MUL_U,
        OP_DET_STEP,
        OP_DET_SUM,
        OP_PIX_MUL,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        DV_BX,
        DV_BY,
        DV_UD,
        DV_TD,
        DV_UO,
        DV_TO,
        DV_GAIN
    } div_sel_t;

    typedef enum logic [1:0] {
        DK_DEFL,
        DK_UNIT,
        DK_JAC,
        DK_GAIN
    } div_kind_t;

    typedef struct packed {
        dp_op_t               op;
        div_sel_t             div_sel;
        logic [DSTEP_W-1:0]   det_step;
    } plm_cmd_t;

    typedef struct packed {
        logic lens_done;
        logic r2_zero;
        logic div_done;
        logic out_free;
    } plm_status_t;

    typedef struct packed {
        logic                      cmd;
        logic [IDX_W-1:0]          lens_index;
        logic signed [MASS_W-1:0]  lens_mass;
        logic signed [COORD_W-1:0] lens_x;
        logic signed [COORD_W-1:0] lens_y;
        logic signed [COORD_W-1:0] ray_x;
        logic signed [COORD_W-1:0] ray_y;
    } ray_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] beta_x;
        logic signed [COORD_W-1:0] beta_y;
        logic [MAG_W-1:0]          magnification;
        logic                      singular;
        logic [PIX_W-1:0]          src_col;
        logic [PIX_W-1:0]          src_row;
        logic                      src_in_range;
        logic [PIX_W-1:0]          img_col;
        logic [PIX_W-1:0]          img_row;
        logic                      img_in_range;
    } res_item_t;
endpackage
`default_nettype wire

/* rtl/plm_ifs.sv */
// valid/ready channel interfaces for rays, results and configuration
`default_nettype none
interface plm_ray_if;
    import plm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [IDX_W-1:0]          lens_index;
    logic signed [MASS_W-1:0]  lens_mass;
    logic signed [COORD_W-1:0] lens_x;
    logic signed [COORD_W-1:0] lens_y;
    logic signed [COORD_W-1:0] ray_x;
    logic signed [COORD_W-1:0] ray_y;
    modport source (output valid, cmd, lens_index, lens_mass, lens_x, lens_y, ray_x, ray_y,
                    input ready);
    modport sink (input valid, cmd, lens_index, lens_mass, lens_x, lens_y, ray_x, ray_y,
                  output ready);
endinterface

interface plm_res_if;
    import plm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] beta_x;
    logic signed [COORD_W-1:0] beta_y;
    logic [MAG_W-1:0]          magnification;
    logic                      singular;
    logic [PIX_W-1:0]          src_col;
    logic [PIX_W-1:0]          src_row;
    logic                      src_in_range;
    logic [PIX_W-1:0]          img_col;
    logic [PIX_W-1:0]          img_row;
    logic                      img_in_range;
    modport source (output valid, beta_x, beta_y, magnification, singular, src_col, src_row,
                    src_in_range, img_col, img_row, img_in_range, input ready);
    modport sink (input valid, beta_x, beta_y, magnification, singular, src_col, src_row,
                  src_in_range, img_col, img_row, img_in_range, output ready);
endinterface

interface plm_cfg_if;
    import plm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/plm_div.sv */
// serial restoring divider, one quotient bit per cycle, capped result
`default_nettype none
module plm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire plm_pkg::div_kind_t         kind,
    input  wire logic [plm_pkg::DIV_W-1:0]  num,
    input  wire logic [plm_pkg::DIV_W-1:0]  den,
    output logic                            done,
    output logic [plm_pkg::QUO_W-1:0]       quot
);
    import plm_pkg::*;

    logic [DIV_W-1:0] rem_reg, low_reg, den_reg;
    logic [QUO_W-1:0] q_reg, cap_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg, done_reg, ovf_reg;

    logic [DIV_W-1:0] hi, low0;
    logic [QUO_W-1:0] cap0;
    logic [5:0]       k0;
    logic [DIV_W:0]   trial, diff;
    logic             ge;

    // split the numerator so that at most k quotient bits remain
    always_comb
    begin
        case (kind)
            DK_DEFL:
            begin
                hi = num >> 53; low0 = num << 43; k0 = 6'd53;
                cap0 = QUO_W'(1) << 52;
            end
            DK_UNIT:
            begin
                hi = num >> 31; low0 = num << 65; k0 = 6'd31;
                cap0 = QUO_W'(1) << 30;
            end
            DK_JAC:
            begin
                hi = num >> 48; low0 = num << 48; k0 = 6'd48;
                cap0 = QUO_W'(1) << 47;
            end
            default:
            begin
                hi = num >> 32; low0 = num << 64; k0 = 6'd32;
                cap0 = QUO_W'(32'hFFFF_FFFF);
            end
        endcase
    end

    assign trial = {rem_reg, low_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0 || hi >= den)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ovf_reg <= (den == '0) || (hi >= den);
            rem_reg <= hi;
            low_reg <= low0;
            den_reg <= den;
            cap_reg <= cap0;
            cnt_reg <= k0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            low_reg <= low_reg << 1;
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    assign done = done_reg;
    assign quot = (ovf_reg || q_reg > cap_reg) ? cap_reg : q_reg;
endmodule
`default_nettype wire

/* rtl/plm_dp.sv */
// datapath: lens tables, config registers, accumulators, jacobian and pixel math
`default_nettype none
module plm_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire plm_pkg::plm_cmd_t             cmd,
    output plm_pkg::plm_status_t               status,
    input  wire plm_pkg::ray_item_t            item,
    input  wire logic                          cfg_we,
    input  wire logic [plm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output plm_pkg::res_item_t                 res
);
    import plm_pkg::*;

    localparam logic signed [48:0] J_ONE = 49'sd4294967296;
    localparam logic signed [49:0] J_LIM = 50'sd140737488355328;

    // configuration
    logic [CNT_W-1:0]          count_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg;
    logic [SCALE_W-1:0]        sx_reg, sy_reg;
    logic [SIZE_W-1:0]         size_reg;

    // lens tables
    logic signed [MASS_W-1:0]  mass_mem [MAX_LENSES];
    logic signed [COORD_W-1:0] lx_mem [MAX_LENSES];
    logic signed [COORD_W-1:0] ly_mem [MAX_LENSES];

    // per ray state
    logic signed [COORD_W-1:0] rx_reg, ry_reg, m_reg, lx_reg, ly_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic signed [57:0]        bx_reg, by_reg;
    logic signed [48:0]        j11_reg, j22_reg, j12_reg;
    logic                      sing_reg;
    logic [31:0]               ax_reg, ay_reg, ma_reg;
    logic                      dxneg_reg, dyneg_reg, mneg_reg, dneg_reg;
    logic [63:0]               sx2_reg, sy2_reg, max_reg, may_reg, axy_reg, nd_reg;
    logic [64:0]               r2_reg;
    logic [30:0]               u_reg;
    logic [61:0]               prod_reg;
    logic [94:0]               p_reg, q_reg;
    logic [DIV_W-1:0]          det_reg;
    logic [MAG_W-1:0]          gain_reg;
    logic signed [COORD_W-1:0] bsx_reg, bsy_reg;
    logic [64:0]               kbx_reg, kby_reg, krx_reg, kry_reg;
    logic                      nbx_reg, nby_reg, nrx_reg, nry_reg;
    logic                      ovalid_reg;
    res_item_t                 res_reg;

    // divider hookup
    logic [DIV_W-1:0] div_num, div_den;
    div_kind_t        div_kind;
    logic             div_done;
    logic [QUO_W-1:0] quot;

    logic [CNT_W-1:0]   n_eff;
    logic [SIZE_W-1:0]  size_eff;
    logic signed [32:0] dx, dy;
    logic [32:0]        ndx, ndy;
    logic [31:0]        nm;
    logic [62:0]        mu;
    logic signed [57:0] defl;
    logic               add11;
    logic [47:0]        m11, m22, m12, da, db;
    logic [23:0]        dxh, dyh;
    logic [47:0]        pp;
    logic [94:0]        pp_sh, acc_in;
    logic [PIX_W:0]     pbx, pby, prx, pry;

    function automatic logic signed [48:0] jstep(input logic signed [48:0] j,
                                                 input logic [47:0] t, input logic add);
        logic signed [49:0] s;
        s = add ? ({j[48], j} + $signed({2'b00, t})) : ({j[48], j} - $signed({2'b00, t}));
        if (s > J_LIM)
            s = J_LIM;
        else if (s < -J_LIM)
            s = -J_LIM;
        return s[48:0];
    endfunction

    function automatic logic [47:0] jmag(input logic signed [48:0] j);
        logic [48:0] n;
        n = -j;
        return j[48] ? n[47:0] : j[47:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [57:0] v);
        if (v > 58'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -58'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [65:0] pmul(input logic signed [COORD_W-1:0] c,
                                         input logic signed [COORD_W-1:0] org,
                                         input logic [SCALE_W-1:0] sc);
        logic signed [32:0] d;
        logic [32:0]        n, m;
        logic [64:0]        k;
        d = {c[31], c} - {org[31], org};
        n = -d;
        m = d[32] ? n : d;
        k = m * sc;
        return {d[32], k};
    endfunction

    // round half away from zero, then range check: {ok, index}
    function automatic logic [PIX_W:0] to_pix(input logic [64:0] k, input logic neg,
                                              input logic [SIZE_W-1:0] sz);
        logic [24:0] r1;
        logic [23:0] r;
        logic        ok;
        r1 = {1'b0, k[64:41]} + 25'd1;
        r  = r1[24:1];
        ok = !(neg && r != '0) && (r < 24'(sz));
        return {ok, r[PIX_W-1:0]};
    endfunction

    assign n_eff    = (count_reg > CNT_W'(MAX_LENSES)) ? CNT_W'(MAX_LENSES) : count_reg;
    assign size_eff = (size_reg > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : size_reg;

    assign dx  = {rx_reg[31], rx_reg} - {lx_reg[31], lx_reg};
    assign dy  = {ry_reg[31], ry_reg} - {ly_reg[31], ly_reg};

    assign ndx = -dx;
    assign ndy = -dy;
    assign nm  = -m_reg;
    assign mu  = ma_reg * u_reg;
    assign defl  = $signed({5'b00000, quot});
    assign add11 = mneg_reg != dneg_reg;

    assign m11 = jmag(j11_reg);
    assign m22 = jmag(j22_reg);
    assign m12 = jmag(j12_reg);
    assign da  = cmd.det_step[2] ? m12 : m11;
    assign db  = cmd.det_step[2] ? m12 : m22;
    assign dxh = cmd.det_step[1] ? da[47:24] : da[23:0];
    assign dyh = cmd.det_step[0] ? db[47:24] : db[23:0];
    assign pp  = dxh * dyh;

    always_comb
    begin
        case (cmd.det_step[1:0])
            2'b00:   pp_sh = 95'(pp);
            2'b11:   pp_sh = 95'(pp) << 48;
            default: pp_sh = 95'(pp) << 24;
        endcase
        if (cmd.det_step[1:0] == 2'b00)
            acc_in = '0;
        else
            acc_in = cmd.det_step[2] ? q_reg : p_reg;
    end

    always_comb
    begin
        div_den = DIV_W'(r2_reg);
        case (cmd.div_sel)
            DV_BX:   begin div_num = DIV_W'(max_reg) << 22;  div_kind = DK_DEFL; end
            DV_BY:   begin div_num = DIV_W'(may_reg) << 22;  div_kind = DK_DEFL; end
            DV_UD:   begin div_num = DIV_W'(nd_reg) << 30;   div_kind = DK_UNIT; end
            DV_UO:   begin div_num = DIV_W'(axy_reg) << 31;  div_kind = DK_UNIT; end
            DV_TD:   begin div_num = DIV_W'(prod_reg) << 24; div_kind = DK_JAC;  end
            DV_TO:   begin div_num = DIV_W'(prod_reg) << 24; div_kind = DK_JAC;  end
            default:
            begin
                div_num  = DIV_W'(1) << 80;
                div_den  = det_reg;
                div_kind = DK_GAIN;
            end
        endcase
    end

    plm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .kind  (div_kind),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    assign pbx = to_pix(kbx_reg, nbx_reg, size_eff);
    assign pby = to_pix(kby_reg, nby_reg, size_eff);
    assign prx = to_pix(krx_reg, nrx_reg, size_eff);
    assign pry = to_pix(kry_reg, nry_reg, size_eff);

    // config registers and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            size_reg   <= SIZE_W'(1024);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LENS_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                    CFG_ORIGIN_X:   ox_reg    <= cfg_data;
                    CFG_ORIGIN_Y:   oy_reg    <= cfg_data;
                    CFG_SCALE_X:    sx_reg    <= cfg_data;
                    CFG_SCALE_Y:    sy_reg    <= cfg_data;
                    CFG_IMAGE_SIZE: size_reg  <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // lens table writes
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            mass_mem[item.lens_index] <= item.lens_mass;
            lx_mem[item.lens_index]   <= item.lens_x;
            ly_mem[item.lens_index]   <= item.lens_y;
        end
    end

    // ray datapath
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                rx_reg   <= item.ray_x;
                ry_reg   <= item.ray_y;
                bx_reg   <= 58'(item.ray_x);
                by_reg   <= 58'(item.ray_y);
                j11_reg  <= J_ONE;
                j22_reg  <= J_ONE;
                j12_reg  <= '0;
                sing_reg <= 1'b0;
                idx_reg  <= '0;
            end
            OP_FETCH:
            begin
                m_reg  <= mass_mem[idx_reg[IDX_W-1:0]];
                lx_reg <= lx_mem[idx_reg[IDX_W-1:0]];
                ly_reg <= ly_mem[idx_reg[IDX_W-1:0]];
            end
            OP_DIFF:
            begin
                ax_reg    <= dx[32] ? ndx[31:0] : dx[31:0];
                ay_reg    <= dy[32] ? ndy[31:0] : dy[31:0];
                dxneg_reg <= dx[32];
                dyneg_reg <= dy[32];
                ma_reg    <= m_reg[31] ? nm : m_reg;
                mneg_reg  <= m_reg[31];
            end
            OP_SQUARE:
            begin
                sx2_reg <= ax_reg * ax_reg;
                sy2_reg <= ay_reg * ay_reg;
                max_reg <= ma_reg * ax_reg;
                may_reg <= ma_reg * ay_reg;
                axy_reg <= ax_reg * ay_reg;
            end
            OP_R2:
            begin
                r2_reg <= {1'b0, sx2_reg} + {1'b0, sy2_reg};
                if (sx2_reg > sy2_reg)
                begin
                    nd_reg   <= sx2_reg - sy2_reg;
                    dneg_reg <= 1'b1;
                end
                else
                begin
                    nd_reg   <= sy2_reg - sx2_reg;
                    dneg_reg <= 1'b0;
                end
            end
            OP_SKIP:
            begin
                sing_reg <= 1'b1;
                idx_reg  <= idx_reg + CNT_W'(1);
            end
            OP_MUL_U:
                prod_reg <= mu[61:0];
            OP_APPLY:
            begin
                case (cmd.div_sel)
                    DV_BX: bx_reg <= (mneg_reg != dxneg_reg) ? bx_reg + defl : bx_reg - defl;
                    DV_BY: by_reg <= (mneg_reg != dyneg_reg) ? by_reg + defl : by_reg - defl;
                    DV_UD: u_reg  <= quot[30:0];
                    DV_UO: u_reg  <= quot[30:0];
                    DV_TD:
                    begin
                        j11_reg <= jstep(j11_reg, quot[47:0], add11);
                        j22_reg <= jstep(j22_reg, quot[47:0], !add11);
                    end
                    DV_TO:
                    begin
                        j12_reg <= jstep(j12_reg, quot[47:0],
                                         mneg_reg != (dxneg_reg != dyneg_reg));
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    default: gain_reg <= quot[MAG_W-1:0];
                endcase
            end
            OP_DET_STEP:
            begin
                if (cmd.det_step[2])
                    q_reg <= acc_in + pp_sh;
                else
                    p_reg <= acc_in + pp_sh;
            end
            OP_DET_SUM:
            begin
                if (j11_reg[48] != j22_reg[48])
                    det_reg <= {1'b0, p_reg} + {1'b0, q_reg};
                else if (p_reg >= q_reg)
                    det_reg <= DIV_W'(p_reg - q_reg);
                else
                    det_reg <= DIV_W'(q_reg - p_reg);
                bsx_reg <= sat32(bx_reg);
                bsy_reg <= sat32(by_reg);
            end
            OP_PIX_MUL:
            begin
                {nbx_reg, kbx_reg} <= pmul(bsx_reg, ox_reg, sx_reg);
                {nby_reg, kby_reg} <= pmul(bsy_reg, oy_reg, sy_reg);
                {nrx_reg, krx_reg} <= pmul(rx_reg, ox_reg, sx_reg);
                {nry_reg, kry_reg} <= pmul(ry_reg, oy_reg, sy_reg);
            end
            OP_OUT:
            begin
                res_reg.beta_x        <= bsx_reg;
                res_reg.beta_y        <= bsy_reg;
                res_reg.magnification <= gain_reg;
                res_reg.singular      <= sing_reg;
                res_reg.src_in_range  <= pbx[PIX_W] & pby[PIX_W];
                res_reg.src_col       <= (pbx[PIX_W] & pby[PIX_W]) ? pbx[PIX_W-1:0] : '0;
                res_reg.src_row       <= (pbx[PIX_W] & pby[PIX_W]) ? pby[PIX_W-1:0] : '0;
                res_reg.img_in_range  <= prx[PIX_W] & pry[PIX_W];
                res_reg.img_col       <= (prx[PIX_W] & pry[PIX_W]) ? prx[PIX_W-1:0] : '0;
                res_reg.img_row       <= (prx[PIX_W] & pry[PIX_W]) ? pry[PIX_W-1:0] : '0;
            end
            default: ;
        endcase
    end

    assign status.lens_done = idx_reg == n_eff;
    assign status.r2_zero   = r2_reg == '0;
    assign status.div_done  = div_done;
    assign status.out_free  = !ovalid_reg || out_ready;
    assign out_valid        = ovalid_reg;
    assign res              = res_reg;
endmodule
`default_nettype wire

/* rtl/plm_ctrl.sv */
// controller: sequences lens loop, divisions, determinant and pixel steps
`default_nettype none
module plm_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 in_cmd,
    output logic                      in_ready,
    output plm_pkg::plm_cmd_t         cmd,
    input  wire plm_pkg::plm_status_t status
);
    import plm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_DIFF,
        S_SQUARE,
        S_R2,
        S_TEST,
        S_DIVS,
        S_DIVW,
        S_APPLY,
        S_MULU,
        S_DET,
        S_DETSUM,
        S_PIX,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    div_sel_t           sel_reg, sel_next;
    logic [DSTEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_cmd == CMD_RAY)
                    begin
                        cmd.op     = OP_START;
                        state_next = S_CHECK;
                    end
                    else
                        cmd.op = OP_LOAD;
                end
            end
            S_CHECK:
            begin
                step_next  = '0;
                state_next = status.lens_done ? S_DET : S_FETCH;
            end
            S_FETCH:  begin cmd.op = OP_FETCH;  state_next = S_DIFF;   end
            S_DIFF:   begin cmd.op = OP_DIFF;   state_next = S_SQUARE; end
            S_SQUARE: begin cmd.op = OP_SQUARE; state_next = S_R2;     end
            S_R2:     begin cmd.op = OP_R2;     state_next = S_TEST;   end
            S_TEST:
            begin
                if (status.r2_zero)
                begin
                    cmd.op     = OP_SKIP;
                    state_next = S_CHECK;
                end
                else
                begin
                    sel_next   = DV_BX;
                    state_next = S_DIVS;
                end
            end
            S_DIVS: begin cmd.op = OP_DIV_START; state_next = S_DIVW; end
            S_DIVW:
            begin
                if (status.div_done)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                cmd.op = OP_APPLY;
                case (sel_reg)
                    DV_BX: begin sel_next = DV_BY; state_next = S_DIVS; end
                    DV_BY: begin sel_next = DV_UD; state_next = S_DIVS; end
                    DV_UD: begin sel_next = DV_TD; state_next = S_MULU; end
                    DV_TD: begin sel_next = DV_UO; state_next = S_DIVS; end
                    DV_UO: begin sel_next = DV_TO; state_next = S_MULU; end
                    DV_TO: state_next = S_CHECK;
                    default: state_next = S_PIX;
                endcase
            end
            S_MULU: begin cmd.op = OP_MUL_U; state_next = S_DIVS; end
            S_DET:
            begin
                cmd.op    = OP_DET_STEP;
                step_next = step_reg + DSTEP_W'(1);
                if (step_reg == '1)
                    state_next = S_DETSUM;
            end
            S_DETSUM:
            begin
                cmd.op     = OP_DET_SUM;
                sel_next   = DV_GAIN;
                state_next = S_DIVS;
            end
            S_PIX: begin cmd.op = OP_PIX_MUL; state_next = S_FINISH; end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.div_sel  = sel_reg;
        cmd.det_step = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= DV_BX;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;
endmodule
`default_nettype wire

/* rtl/point_mass_lens_ray_shooter.sv */
// top level: point mass lens inverse ray shooter
// a load transfer is written to the lens tables and the input is ready again in the next cycle
// a ray result becomes valid after the lens loop and the determinant, reciprocal and pixel steps; a
// lens on the ray is skipped when r2 is zero and a capped quotient ends its division early; the shared
// serial divider produces one quotient bit per cycle (six divisions per lens plus one final reciprocal)
// one ray in flight; reset clears control, output valid and config (image size back to 1024) only
`default_nettype none
module point_mass_lens_ray_shooter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    plm_ray_if.sink    ray_in,
    plm_res_if.source  res_out,
    plm_cfg_if.sink    cfg
);
    import plm_pkg::*;

    plm_cmd_t    cmd;
    plm_status_t status;
    ray_item_t   item;
    res_item_t   res;
    logic        in_ready;
    logic        in_fire;
    logic        out_valid;

    // input transfer happens only while the controller sits idle
    assign ray_in.ready = in_ready;
    assign in_fire      = ray_in.valid && in_ready;

    assign item.cmd        = ray_in.cmd;
    assign item.lens_index = ray_in.lens_index;
    assign item.lens_mass  = ray_in.lens_mass;
    assign item.lens_x     = ray_in.lens_x;
    assign item.lens_y     = ray_in.lens_y;
    assign item.ray_x      = ray_in.ray_x;
    assign item.ray_y      = ray_in.ray_y;

    // config writes are always taken
    assign cfg.ready = 1'b1;

    plm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_cmd   (ray_in.cmd),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    plm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_ready (res_out.ready),
        .out_valid (out_valid),
        .res       (res)
    );

    // result register drives the output channel
    assign res_out.valid         = out_valid;
    assign res_out.beta_x        = res.beta_x;
    assign res_out.beta_y        = res.beta_y;
    assign res_out.magnification = res.magnification;
    assign res_out.singular      = res.singular;
    assign res_out.src_col       = res.src_col;
    assign res_out.src_row       = res.src_row;
    assign res_out.src_in_range  = res.src_in_range;
    assign res_out.img_col       = res.img_col;
    assign res_out.img_row       = res.img_row;
    assign res_out.img_in_range  = res.img_in_range;

    // a ray transfer makes the block busy in the next cycle
    a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ray_in.valid && ray_in.ready && ray_in.cmd == CMD_RAY |=> !ray_in.ready)
        else $error("ray transfer did not start work");

    // a lens load leaves the input ready in the next cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        ray_in.valid && ray_in.ready && ray_in.cmd == CMD_LOAD |=> ray_in.ready)
        else $error("lens load stalled the input");

    // out of range image pixels report zero indices
    a_img_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.img_in_range |-> res_out.img_col == '0 && res_out.img_row == '0)
        else $error("image pixel index not cleared");
endmodule
`default_nettype wire
